FILE: hw/rtl/sise_pkg.sv
// ---------------------------------------------------------------------------
// sise_pkg
// Shared types and constants of the sorted integer set engine.
// ---------------------------------------------------------------------------
package sise_pkg;

    localparam int CAPACITY = 16;
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_SPARE  = 2'd3   // decoded as lookup
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_FOUND    = 3'd3,
        ST_MISSING  = 3'd4,
        ST_REMOVED  = 3'd5
    } t_status;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;     // capture an accepted request
        logic compare;  // register per-entry compare vectors
        logic commit;   // update store, load result register
    } t_dp_cmd;

endpackage

FILE: hw/rtl/sise_datapath.sv
// ---------------------------------------------------------------------------
// sise_datapath
// Row of entry registers with one compare cell and one shift mux per entry.
// ---------------------------------------------------------------------------
module sise_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sise_pkg::t_dp_cmd             i_cmd,
    input  logic [sise_pkg::REQ_W-1:0]    i_req_type,
    input  logic signed [sise_pkg::KEY_W-1:0] i_key_value,
    output logic [sise_pkg::STATUS_W-1:0] o_status,
    output logic [sise_pkg::COUNT_W-1:0]  o_entry_count
);
    import sise_pkg::*;

    logic [REQ_W-1:0]        r_req_type;
    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] r_entries [CAPACITY];
    logic signed [KEY_W-1:0] n_entries [CAPACITY];
    logic [OCC_W-1:0]        r_occ;
    logic [OCC_W-1:0]        n_occ;
    logic [CAPACITY-1:0]     r_lt;
    logic [CAPACITY-1:0]     r_eq;
    logic [CAPACITY-1:0]     n_lt;
    logic [CAPACITY-1:0]     n_eq;
    t_status                 r_status;
    t_status                 n_status;
    logic                    hit;
    logic                    full;
    logic                    do_ins;
    logic                    do_del;

    // Compare cells: entries below the key, and the matching entry.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_lt[i] = (OCC_W'(i) < r_occ) && (r_entries[i] < r_key);
            n_eq[i] = (OCC_W'(i) < r_occ) && (r_entries[i] == r_key);
        end
    end

    assign hit  = |r_eq;
    assign full = (r_occ == OCC_W'(CAPACITY));

    always_comb begin
        do_ins   = 1'b0;
        do_del   = 1'b0;
        n_occ    = r_occ;
        n_status = ST_MISSING;
        case (t_req'(r_req_type))
            REQ_INSERT: begin
                if (hit) begin
                    n_status = ST_PRESENT;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_INSERTED;
                    do_ins   = 1'b1;
                    n_occ    = r_occ + OCC_W'(1);
                end
            end
            REQ_DELETE: begin
                if (hit) begin
                    n_status = ST_REMOVED;
                    do_del   = 1'b1;
                    n_occ    = r_occ - OCC_W'(1);
                end
            end
            default: begin
                n_status = hit ? ST_FOUND : ST_MISSING;
            end
        endcase
    end

    // Shift cells: insert opens a slot at the first entry not below the key,
    // delete closes the gap left by the matching entry.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [KEY_W-1:0] lower;
        logic signed [KEY_W-1:0] upper;
        logic                    lower_lt;
        if (g == 0) begin : g_first
            assign lower    = r_key;
            assign lower_lt = 1'b1;
        end else begin : g_rest
            assign lower    = r_entries[g-1];
            assign lower_lt = r_lt[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign upper = r_entries[g];
        end else begin : g_mid
            assign upper = r_entries[g+1];
        end

        always_comb begin
            n_entries[g] = r_entries[g];
            if (do_ins && !r_lt[g]) begin
                n_entries[g] = lower_lt ? r_key : lower;
            end else if (do_del && !r_lt[g]) begin
                n_entries[g] = upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.commit) begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type <= i_req_type;
            r_key      <= i_key_value;
        end
        if (i_cmd.compare) begin
            r_lt <= n_lt;
            r_eq <= n_eq;
        end
        if (i_cmd.commit) begin
            r_status <= n_status;
            for (int i = 0; i < CAPACITY; i++) begin
                r_entries[i] <= n_entries[i];
            end
        end
    end

    assign o_status      = r_status;
    assign o_entry_count = COUNT_W'(r_occ);

endmodule

FILE: hw/rtl/sise_ctrl.sv
// ---------------------------------------------------------------------------
// sise_ctrl
// Request sequencer: accept, compare, commit; owns the result valid flag.
// ---------------------------------------------------------------------------
module sise_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sise_pkg::t_dp_cmd o_cmd
);
    import sise_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd         = '0;
        n_state       = r_state;
        n_out_valid   = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: hw/rtl/sorted_integer_set_engine_top.sv
// Sequence: request accept and capture, compare, then commit; the commit, and with it
//   result valid, waits while an earlier result is still held. A new request is taken
//   only once the previous one commits, also while the previous result waits.
// Reset (i_rst_n low, synchronous): entry count cleared, sequencer idle,
//   no result pending. Entry contents are not cleared.
// ---------------------------------------------------------------------------
// sorted_integer_set_engine_top
// Sorted set of distinct signed 32-bit values with insert, lookup and delete.
// ---------------------------------------------------------------------------
module sorted_integer_set_engine_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [sise_pkg::REQ_W-1:0]         i_req_type,
    input  logic signed [sise_pkg::KEY_W-1:0]  i_key_value,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [sise_pkg::STATUS_W-1:0]      o_status,
    output logic [sise_pkg::COUNT_W-1:0]       o_entry_count
);
    import sise_pkg::*;

    t_dp_cmd cmd;

    // Sequencer: one request in flight; the result register in the datapath
    // holds the last answer until the consumer takes it.
    sise_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // Entry row: every entry compares against the key in parallel, then each
    // cell picks its neighbor, itself or the key to open or close a slot.
    sise_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_req_type    (i_req_type),
        .i_key_value   (i_key_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

endmodule

FILE: hw/rtl/sise_checker.sv
// ---------------------------------------------------------------------------
// sise_checker
// Port-level checks of the sorted integer set engine, bound to the top level.
// ---------------------------------------------------------------------------
module sise_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [sise_pkg::STATUS_W-1:0]      o_status,
    input logic [sise_pkg::COUNT_W-1:0]       o_entry_count
);
    import sise_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_entry_count))
        else $error("result changed while stalled");

    // one request in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while another in flight");

    // a new result only appears after a request was being worked on
    a_result_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result without request");

    // status code is a defined code whenever a result is valid
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= ST_REMOVED)
        else $error("undefined status code");

endmodule

bind sorted_integer_set_engine_top sise_checker u_sise_checker (.*);

FILE: verif/sorted_integer_set_engine_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sorted_integer_set_engine_top_tb
// Self-checking bench for the sorted integer set engine. A queue of planned
// requests feeds a clocked driver; a clocked monitor predicts every accepted
// request against a shadow copy of the sorted set and checks each result in
// order. Pacing phases vary sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module sorted_integer_set_engine_top_tb;

    import sise_pkg::*;

    localparam int HOLD_CYCLES  = 200;   // long result-side hold-off
    localparam int WATCHDOG_MAX = 4000;  // cycles with no handshake at all
    localparam int TAIL_CYCLES  = 20;    // settle time after last result
    localparam int PHASE_ITEMS  = 500;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    // Pacing of both channels, carried by each planned request.
    typedef enum logic [1:0] {
        PACE_FULL,        // no idling on either side
        PACE_SEND_IDLE,   // sender idles with a 46 percent chance
        PACE_RECV_STALL,  // receiver stalls with a 46 percent chance
        PACE_BOTH         // both sides at a 20 percent chance
    } t_pace;

    typedef struct {
        t_req                    op;
        logic signed [KEY_W-1:0] key;
        t_pace                   pace;
        bit                      drain;  // wait for every result before sending
        bit                      choke;  // receiver holds off once this is taken
    } t_set_request;

    typedef struct {
        t_status              status;
        logic [COUNT_W-1:0]   count;
    } t_set_answer;

    // DUT connections; every input known from time zero.
    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_ready;
    logic [REQ_W-1:0]           i_req_type  = '0;
    logic signed [KEY_W-1:0]    i_key_value = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [STATUS_W-1:0]        o_status;
    logic [COUNT_W-1:0]         o_entry_count;

    // Bench state.
    t_set_request               request_backlog[$];
    t_set_answer                pending_results[$];
    t_set_request               in_flight;
    t_pace                      cur_pace     = PACE_FULL;
    bit                         req_taken    = 1'b0;
    bit                         choke_armed  = 1'b0;
    int                         hold_left    = 0;
    int                         fault_count  = 0;
    int                         idle_cycles  = 0;

    // Shadow copy of the set: ascending values in slots 0..set_size-1.
    logic signed [KEY_W-1:0]    set_vals[CAPACITY];
    int                         set_size = 0;

    always #2 i_clk = ~i_clk;

    sorted_integer_set_engine_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_key_value   (i_key_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    // -----------------------------------------------------------------------
    // Set predictor: applies one request to the shadow set and returns the
    // status and count the engine must report for it.
    // -----------------------------------------------------------------------
    function automatic t_set_answer apply_set_op(input t_req op,
                                                 input logic signed [KEY_W-1:0] key);
        t_set_answer ans;
        int          slot;
        bit          hit;
        slot = 0;
        // first slot holding a value >= key (set_size if none)
        while (slot < set_size && set_vals[slot] < key)
            slot++;
        hit = (slot < set_size) && (set_vals[slot] == key);
        case (op)
            REQ_INSERT: begin
                if (hit) begin
                    ans.status = ST_PRESENT;          // duplicate wins even when full
                end else if (set_size >= CAPACITY) begin
                    ans.status = ST_FULL;
                end else begin
                    for (int j = set_size; j > slot; j--)
                        set_vals[j] = set_vals[j-1];
                    set_vals[slot] = key;
                    set_size++;
                    ans.status = ST_INSERTED;
                end
            end
            REQ_DELETE: begin
                if (hit) begin
                    for (int j = slot; j < set_size - 1; j++)
                        set_vals[j] = set_vals[j+1];
                    set_size--;
                    ans.status = ST_REMOVED;
                end else begin
                    ans.status = ST_MISSING;
                end
            end
            default: begin
                // lookup, and the spare code decodes the same way
                ans.status = hit ? ST_FOUND : ST_MISSING;
            end
        endcase
        ans.count = set_size[COUNT_W-1:0];
        return ans;
    endfunction

    function automatic void queue_req(input t_req op, input logic signed [KEY_W-1:0] key,
                                      input t_pace pace, input bit drain, input bit choke);
        t_set_request r;
        r.op    = op;
        r.key   = key;
        r.pace  = pace;
        r.drain = drain;
        r.choke = choke;
        request_backlog.push_back(r);
    endfunction

    // One pacing phase of random traffic. Keys come mostly from a small pool
    // (extremes, a cluster of neighbors, scattered values) so that hits,
    // duplicates and a full table all happen; the pool is larger than the
    // capacity. Insert-heavy and delete-heavy stretches alternate so the
    // fill level sweeps between empty and full.
    function automatic void plan_phase(input t_pace pace);
        logic signed [KEY_W-1:0] key_pool[20];
        logic signed [KEY_W-1:0] base;
        logic signed [KEY_W-1:0] key;
        t_req                    op;
        int                      ins_pct;
        int                      r;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 100 == 0) begin
                base = $urandom;
                key_pool[0] = KEY_MIN;
                key_pool[1] = KEY_MAX;
                key_pool[2] = '0;
                key_pool[3] = -1;
                for (int i = 4; i < 12; i++)
                    key_pool[i] = base + i;
                for (int i = 12; i < 20; i++)
                    key_pool[i] = $urandom;
            end
            ins_pct = ((n / 40) % 2 == 0) ? 55 : 20;
            r = $urandom_range(99);
            if (r < 5)
                op = REQ_SPARE;
            else if (r < 5 + ins_pct)
                op = REQ_INSERT;
            else if (r < 25 + ins_pct)
                op = REQ_LOOKUP;
            else
                op = REQ_DELETE;
            // occasional key from the whole range
            key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(19)];
            queue_req(op, key, pace, (n == 0) || (n == 250), (n == 10) || (n == 300));
        end
    endfunction

    // -----------------------------------------------------------------------
    // Request driver: new request on the falling edge once the previous one
    // was taken. Valid stays up with a steady payload until accepted.
    // -----------------------------------------------------------------------
    always @(negedge i_clk) begin : request_driver
        int idle_pct;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_taken) begin
            if (request_backlog.size() == 0) begin
                i_in_valid <= 1'b0;
            end else begin
                idle_pct = (request_backlog[0].pace == PACE_SEND_IDLE) ? 46 :
                           (request_backlog[0].pace == PACE_BOTH)      ? 20 : 0;
                if (request_backlog[0].drain && pending_results.size() != 0) begin
                    i_in_valid <= 1'b0;                 // hold until all results are in
                end else if ($urandom_range(99) < idle_pct) begin
                    i_in_valid <= 1'b0;
                end else begin
                    in_flight = request_backlog.pop_front();
                    // drain gates only the request that carries it, once it is at the head
                    i_in_valid  <= 1'b1;
                    i_req_type  <= in_flight.op;
                    i_key_value <= in_flight.key;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Result-side ready: random stalls per phase, plus a long hold-off armed
    // by the monitor so results stall and back up the request side.
    // -----------------------------------------------------------------------
    always @(negedge i_clk) begin : result_ready
        int stall_pct;
        stall_pct = (cur_pace == PACE_RECV_STALL) ? 46 :
                    (cur_pace == PACE_BOTH)       ? 20 : 0;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (choke_armed) begin
                hold_left   = HOLD_CYCLES;
                choke_armed = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: on the rising edge, predict each accepted request and check
    // each accepted result against the oldest prediction.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin : set_monitor
        t_set_answer want;
        if (!i_rst_n) begin
            req_taken = 1'b0;
        end else begin
            req_taken = i_in_valid && o_in_ready;
            if (req_taken) begin
                pending_results.push_back(apply_set_op(t_req'(i_req_type), i_key_value));
                cur_pace = in_flight.pace;
                if (in_flight.choke)
                    choke_armed = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: result with no request pending: status %0d count %0d",
                                 $realtime, o_status, o_entry_count);
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status || o_entry_count !== want.count) begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("%0t: mismatch: status exp %0d got %0d, count exp %0d got %0d",
                                     $realtime, want.status, o_status, want.count,
                                     o_entry_count);
                    end
                end
            end
        end
    end

    // Watchdog: ends a hung run.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus plan, reset and end of run.
    // -----------------------------------------------------------------------
    initial begin
        // directed: empty table, extremes, duplicate, spare code, removal of
        // the first entry, absent delete, fill to capacity, full and
        // duplicate-on-full
        queue_req(REQ_LOOKUP, 7, PACE_FULL, 1'b0, 1'b0);        // lookup on empty
        queue_req(REQ_DELETE, 7, PACE_FULL, 1'b0, 1'b0);        // delete on empty
        queue_req(REQ_INSERT, KEY_MIN, PACE_FULL, 1'b0, 1'b0);
        queue_req(REQ_INSERT, KEY_MAX, PACE_FULL, 1'b0, 1'b0);
        queue_req(REQ_INSERT, 0, PACE_FULL, 1'b0, 1'b0);
        queue_req(REQ_INSERT, KEY_MIN, PACE_FULL, 1'b0, 1'b0);  // already present
        queue_req(REQ_SPARE, KEY_MAX, PACE_FULL, 1'b0, 1'b0);   // spare code acts as lookup
        queue_req(REQ_DELETE, KEY_MIN, PACE_FULL, 1'b0, 1'b0);  // remove first entry
        queue_req(REQ_DELETE, -5, PACE_FULL, 1'b0, 1'b0);       // absent value
        for (int k = -7; k < 7; k++)
            queue_req(REQ_INSERT, k * 1000 + 7, PACE_FULL, 1'b0, 1'b0);
        queue_req(REQ_INSERT, 12345, PACE_FULL, 1'b0, 1'b0);    // table full
        queue_req(REQ_INSERT, KEY_MAX, PACE_FULL, 1'b0, 1'b0);  // duplicate while full

        plan_phase(PACE_FULL);
        plan_phase(PACE_SEND_IDLE);
        plan_phase(PACE_RECV_STALL);
        plan_phase(PACE_BOTH);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_backlog.size() != 0 || i_in_valid || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            fault_count++;
            $display("%0d results never arrived", pending_results.size());
        end
        if (fault_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
